// ----- rtl/pf_pkg.sv -----
// Shared constants, types and helpers for the Playfair digraph encryptor.
package pf_pkg;

  localparam int unsigned SqDim    = 5;
  localparam int unsigned LetterW  = 5;
  localparam int unsigned PosW     = 3;
  localparam int unsigned CellCnt  = SqDim * SqDim;
  localparam int unsigned RowW     = SqDim * LetterW;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [LetterW-1:0] CodeI = 5'd8;
  localparam logic [LetterW-1:0] CodeJ = 5'd9;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [RowW-1:0]    key_row_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_ROW_ZERO  = 3'd0,
    REG_KEY_ROW_ONE   = 3'd1,
    REG_KEY_ROW_TWO   = 3'd2,
    REG_KEY_ROW_THREE = 3'd3,
    REG_KEY_ROW_FOUR  = 3'd4
  } cfg_idx_t;

  // Location of one letter in the square
  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } loc_t;

  // Cell coordinates picked for one output letter
  typedef struct packed {
    pos_t row;
    pos_t col;
  } cell_sel_t;

  function automatic pos_t wrap_inc(input pos_t p);
    if (p == pos_t'(SqDim - 1)) begin
      return '0;
    end
    return p + pos_t'(1);
  endfunction

endpackage

// ----- rtl/pf_ifs.sv -----
// Handshake channel interfaces: digraph input, cipher output, register write.
interface pf_in_if;
  logic               valid;
  logic               ready;
  pf_pkg::letter_t    plain_first;
  pf_pkg::letter_t    plain_second;

  modport source (output valid, output plain_first, output plain_second, input ready);
  modport sink   (input valid, input plain_first, input plain_second, output ready);
endinterface

interface pf_out_if;
  logic               valid;
  logic               ready;
  pf_pkg::letter_t    cipher_first;
  pf_pkg::letter_t    cipher_second;
  logic               letter_missing;

  modport source (output valid, output cipher_first, output cipher_second,
                  output letter_missing, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second,
                  input letter_missing, output ready);
endinterface

interface pf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pf_pkg::CfgIdxW-1:0]    index;
  pf_pkg::key_row_t              data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/playfair_digraph_encrypt.sv -----
// Playfair digraph encryptor: key square registers and four-stage pipeline.
//
// Encrypts one plaintext digraph per word against a 5x5 key square held in five
// row registers (register i is row i, column 0 in the low five bits). The
// pipeline takes a new word every clock while the output is not stalled, and
// each result passes through four registers in turn: stage one compares both
// letters against all 25 cells, stage two priority-encodes the first row-major
// match, stage three applies the row, column or rectangle rule, and the output
// register selects the cell letters. Back-pressure on the output stalls the
// stages in place without losing or repeating a word. Key writes are taken
// every cycle and should only be issued while the pipeline is empty. A letter
// I also matches a cell holding J; a letter missing from the square raises
// letter_missing and gives zero cipher letters.
module playfair_digraph_encrypt (
  input  logic          clk,
  input  logic          rst,
  pf_cfg_if.sink        cfg,
  pf_in_if.sink         din,
  pf_out_if.source      dout
);

  pf_pkg::letter_t key [pf_pkg::SqDim][pf_pkg::SqDim];
  pf_pkg::key_row_t key_row [pf_pkg::SqDim];

  // Key square registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < pf_pkg::SqDim; r++) begin
        key_row[r] <= '0;
      end
    end else if (cfg.valid) begin
      unique case (pf_pkg::cfg_idx_t'(cfg.index))
        pf_pkg::REG_KEY_ROW_ZERO:  key_row[0] <= cfg.data;
        pf_pkg::REG_KEY_ROW_ONE:   key_row[1] <= cfg.data;
        pf_pkg::REG_KEY_ROW_TWO:   key_row[2] <= cfg.data;
        pf_pkg::REG_KEY_ROW_THREE: key_row[3] <= cfg.data;
        pf_pkg::REG_KEY_ROW_FOUR:  key_row[4] <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < pf_pkg::SqDim; r++) begin
      for (int c = 0; c < pf_pkg::SqDim; c++) begin
        key[r][c] = key_row[r][c*pf_pkg::LetterW +: pf_pkg::LetterW];
      end
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on
  logic v1, v2, v3, vo;
  logic en1, en2, en3, en_o;

  assign en_o      = !vo || dout.ready;
  assign en3       = !v3 || en_o;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign din.ready = en1;

  // Stage one: compare both letters against every cell
  logic [pf_pkg::CellCnt-1:0] hit_a, hit_b, hit_a_next, hit_b_next;

  always_comb begin
    for (int r = 0; r < pf_pkg::SqDim; r++) begin
      for (int c = 0; c < pf_pkg::SqDim; c++) begin
        hit_a_next[r*pf_pkg::SqDim + c] = (key[r][c] == din.plain_first) ||
          (key[r][c] == pf_pkg::CodeJ && din.plain_first == pf_pkg::CodeI);
        hit_b_next[r*pf_pkg::SqDim + c] = (key[r][c] == din.plain_second) ||
          (key[r][c] == pf_pkg::CodeJ && din.plain_second == pf_pkg::CodeI);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      hit_a <= hit_a_next;
      hit_b <= hit_b_next;
    end
  end

  // Stage two: first match in row-major order
  pf_pkg::loc_t loc_a, loc_b, loc_a_next, loc_b_next;

  always_comb begin
    loc_a_next = '0;
    loc_b_next = '0;
    // walk downward so the lowest matching cell wins
    for (int r = pf_pkg::SqDim - 1; r >= 0; r--) begin
      for (int c = pf_pkg::SqDim - 1; c >= 0; c--) begin
        if (hit_a[r*pf_pkg::SqDim + c]) begin
          loc_a_next.found = 1'b1;
          loc_a_next.row   = pf_pkg::PosW'(r);
          loc_a_next.col   = pf_pkg::PosW'(c);
        end
        if (hit_b[r*pf_pkg::SqDim + c]) begin
          loc_b_next.found = 1'b1;
          loc_b_next.row   = pf_pkg::PosW'(r);
          loc_b_next.col   = pf_pkg::PosW'(c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      loc_a <= loc_a_next;
      loc_b <= loc_b_next;
    end
  end

  // Stage three: pick the output cells
  pf_pkg::cell_sel_t sel_a, sel_b, sel_a_next, sel_b_next;
  logic missing, missing_next;

  assign missing_next = !loc_a.found || !loc_b.found;

  always_comb begin
    priority if (loc_a.row == loc_b.row) begin
      sel_a_next = '{row: loc_a.row, col: pf_pkg::wrap_inc(loc_a.col)};
      sel_b_next = '{row: loc_b.row, col: pf_pkg::wrap_inc(loc_b.col)};
    end else if (loc_a.col == loc_b.col) begin
      sel_a_next = '{row: pf_pkg::wrap_inc(loc_a.row), col: loc_a.col};
      sel_b_next = '{row: pf_pkg::wrap_inc(loc_b.row), col: loc_b.col};
    end else begin
      sel_a_next = '{row: loc_a.row, col: loc_b.col};
      sel_b_next = '{row: loc_b.row, col: loc_a.col};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sel_a   <= sel_a_next;
      sel_b   <= sel_b_next;
      missing <= missing_next;
    end
  end

  // Output register: read the selected cells
  pf_pkg::letter_t cipher_a, cipher_b;
  logic            missing_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en_o) begin
      vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      missing_o <= missing;
      if (missing) begin
        cipher_a <= '0;
        cipher_b <= '0;
      end else begin
        cipher_a <= key[sel_a.row][sel_a.col];
        cipher_b <= key[sel_b.row][sel_b.col];
      end
    end
  end

  assign dout.valid          = vo;
  assign dout.cipher_first   = cipher_a;
  assign dout.cipher_second  = cipher_b;
  assign dout.letter_missing = missing_o;

endmodule

// ----- tb/playfair_digraph_encrypt_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard: mirrors the key square, predicts each cipher word and checks the output channel.
module playfair_digraph_encrypt_checker
  import pf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pf_cfg_if    cfg,
  pf_in_if     din,
  pf_out_if    dout,
  output int   mismatches,
  output int   in_flight
);

  localparam int MaxReports = 60;

  typedef struct packed {
    letter_t plain_first;
    letter_t plain_second;
    letter_t cipher_first;
    letter_t cipher_second;
    logic    letter_missing;
  } cipher_word_t;

  key_row_t     square [SqDim];
  cipher_word_t pending_ciphers [$];

  function automatic letter_t cell_letter(pos_t r, pos_t c);
    return square[r][LetterW*c +: LetterW];
  endfunction

  function automatic pos_t step_on(pos_t p);
    return pos_t'((p + 1) % SqDim);
  endfunction

  // First row-major match wins; a plaintext I also takes a J cell
  function automatic loc_t find_letter(letter_t ch);
    loc_t    loc;
    letter_t v;
    loc = '0;
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        v = cell_letter(pos_t'(r), pos_t'(c));
        if (!loc.found && (v == ch || (v == CodeJ && ch == CodeI))) begin
          loc.found = 1'b1;
          loc.row   = pos_t'(r);
          loc.col   = pos_t'(c);
        end
      end
    end
    return loc;
  endfunction

  function automatic cipher_word_t encrypt_digraph(letter_t a, letter_t b);
    cipher_word_t w;
    loc_t         la;
    loc_t         lb;
    w = '0;
    w.plain_first  = a;
    w.plain_second = b;
    la = find_letter(a);
    lb = find_letter(b);
    if (!la.found || !lb.found) begin
      w.letter_missing = 1'b1;
    end else if (la.row == lb.row) begin
      // same cell lands here too
      w.cipher_first  = cell_letter(la.row, step_on(la.col));
      w.cipher_second = cell_letter(lb.row, step_on(lb.col));
    end else if (la.col == lb.col) begin
      w.cipher_first  = cell_letter(step_on(la.row), la.col);
      w.cipher_second = cell_letter(step_on(lb.row), lb.col);
    end else begin
      w.cipher_first  = cell_letter(la.row, lb.col);
      w.cipher_second = cell_letter(lb.row, la.col);
    end
    return w;
  endfunction

  task automatic report(string msg);
    if (mismatches < MaxReports) begin
      $display("[%0t] %s", $time, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    cipher_word_t want;
    if (rst) begin
      for (int r = 0; r < SqDim; r++) square[r] = '0;
      pending_ciphers.delete();
    end else begin
      if (cfg.valid && cfg.ready && cfg.index < SqDim) begin
        square[cfg.index] = cfg.data;
      end
      if (din.valid && din.ready) begin
        pending_ciphers.push_back(encrypt_digraph(din.plain_first, din.plain_second));
      end
      if (dout.valid && dout.ready) begin
        if (pending_ciphers.size() == 0) begin
          report($sformatf("unexpected word %0d,%0d missing=%0b", dout.cipher_first,
                           dout.cipher_second, dout.letter_missing));
        end else begin
          want = pending_ciphers.pop_front();
          if (dout.cipher_first !== want.cipher_first)
            report($sformatf("digraph %0d,%0d: cipher_first %0d, want %0d", want.plain_first,
                             want.plain_second, dout.cipher_first, want.cipher_first));
          if (dout.cipher_second !== want.cipher_second)
            report($sformatf("digraph %0d,%0d: cipher_second %0d, want %0d", want.plain_first,
                             want.plain_second, dout.cipher_second, want.cipher_second));
          if (dout.letter_missing !== want.letter_missing)
            report($sformatf("digraph %0d,%0d: letter_missing %0b, want %0b", want.plain_first,
                             want.plain_second, dout.letter_missing, want.letter_missing));
        end
      end
    end
    in_flight <= pending_ciphers.size();
  end

endmodule

// ----- tb/playfair_digraph_encrypt_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, key and digraph stimulus, and the final verdict.
module playfair_digraph_encrypt_tb;
  import pf_pkg::*;

  localparam int      Codes          = 1 << LetterW;
  localparam int      RandomPerPhase = 155;
  localparam int      SettleCycles   = 12;
  localparam longint  TimeoutNs      = 5_000_000;
  localparam letter_t TopCode        = '1;
  localparam letter_t FirstSpare     = 5'd26;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  int       mismatches;
  int       in_flight;
  key_row_t key_plan [SqDim];

  pf_cfg_if cfg_ch ();
  pf_in_if  din_ch ();
  pf_out_if dout_ch ();

  playfair_digraph_encrypt dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .din  (din_ch),
    .dout (dout_ch)
  );

  playfair_digraph_encrypt_checker cipher_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .din        (din_ch),
    .dout       (dout_ch),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic letter_t ltr(byte ch);
    return letter_t'(ch - "A");
  endfunction

  function automatic void set_cell(int i, letter_t v);
    key_plan[i / SqDim][LetterW*(i % SqDim) +: LetterW] = v;
  endfunction

  function automatic void key_from_text(string s);
    for (int i = 0; i < CellCnt; i++) set_cell(i, ltr(s[i]));
  endfunction

  // 25 distinct codes drawn from all 32
  function automatic void key_distinct();
    letter_t pool [Codes];
    letter_t tmp;
    int      j;
    for (int i = 0; i < Codes; i++) pool[i] = letter_t'(i);
    for (int i = Codes - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (int i = 0; i < CellCnt; i++) set_cell(i, pool[i]);
  endfunction

  // Mostly letters from the square, some I, some arbitrary codes
  function automatic letter_t pick_letter();
    int roll;
    int r;
    int c;
    roll = $urandom_range(0, 9);
    r = $urandom_range(0, SqDim - 1);
    c = $urandom_range(0, SqDim - 1);
    if (roll < 7) return key_plan[r][LetterW*c +: LetterW];
    if (roll == 7) return CodeI;
    return letter_t'($urandom_range(0, Codes - 1));
  endfunction

  task automatic send_digraph(letter_t a, letter_t b);
    din_ch.valid        <= 1'b1;
    din_ch.plain_first  <= a;
    din_ch.plain_second <= b;
    do @(posedge clk); while (!din_ch.ready);
  endtask

  task automatic hold_off(int cycles);
    din_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Pause the sender until every expected word is back
  task automatic drain();
    din_ch.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, key_row_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_key();
    for (int r = 0; r < SqDim; r++) write_reg(cfg_idx_t'(r), key_plan[r]);
    // an index past the last row must be dropped
    write_reg(CfgIdxW'($urandom_range(SqDim, (1 << CfgIdxW) - 1)), key_row_t'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_digraph(pick_letter(), pick_letter());
        sent++;
      end
      case ($urandom_range(0, 19))
        0: drain();
        1, 2, 3, 4, 5, 6: ;
        default: hold_off($urandom_range(1, 12));
      endcase
    end
  endtask

  // Output back-pressure in modes of random length
  initial begin
    rx_mode_t mode;
    int       left;
    dout_ch.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(RX_OPEN, RX_PERIODIC));
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        RX_OPEN:   dout_ch.ready <= 1'b1;
        RX_MOSTLY: dout_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: dout_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   dout_ch.ready <= ((left % 8) < 3);
      endcase
    end
  end

  initial begin
    din_ch.valid        = 1'b0;
    din_ch.plain_first  = '0;
    din_ch.plain_second = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    for (int r = 0; r < SqDim; r++) key_plan[r] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset square: every cell is A
    send_digraph(ltr("A"), ltr("A"));
    send_digraph(ltr("A"), ltr("B"));
    send_digraph(ltr("B"), ltr("A"));
    run_random(40);
    drain();

    key_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ");
    load_key();
    send_digraph(ltr("P"), ltr("Y"));
    send_digraph(ltr("F"), ltr("P"));
    send_digraph(ltr("P"), ltr("B"));
    send_digraph(ltr("T"), ltr("P"));
    send_digraph(ltr("H"), ltr("I"));
    send_digraph(ltr("A"), ltr("A"));
    send_digraph(ltr("Z"), ltr("Z"));
    send_digraph(CodeJ, ltr("A"));
    send_digraph(ltr("A"), CodeJ);
    send_digraph(TopCode, ltr("A"));
    send_digraph(ltr("A"), FirstSpare);
    send_digraph(ltr("A"), ltr("Z"));
    send_digraph(ltr("Z"), ltr("A"));
    hold_off(3);
    run_random(RandomPerPhase);
    drain();

    // J stands where I was: a plaintext I finds it, J finds itself
    key_from_text("PLAYFJREXMBCDGHKNOQSTUVWZ");
    load_key();
    send_digraph(CodeI, ltr("A"));
    send_digraph(ltr("A"), CodeI);
    send_digraph(CodeI, CodeI);
    send_digraph(CodeJ, CodeJ);
    send_digraph(CodeJ, CodeI);
    run_random(RandomPerPhase);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0, 4: key_distinct();
        1, 5: for (int r = 0; r < SqDim; r++) key_plan[r] = key_row_t'($urandom);
        2: begin
          // heavy repeats of I, J, A and B stress the first-match rule
          for (int i = 0; i < CellCnt; i++) begin
            case ($urandom_range(0, 3))
              0: set_cell(i, CodeI);
              1: set_cell(i, CodeJ);
              2: set_cell(i, ltr("A"));
              default: set_cell(i, ltr("B"));
            endcase
          end
        end
        3: for (int r = 0; r < SqDim; r++) key_plan[r] = '1;
        default: for (int r = 0; r < SqDim; r++) key_plan[r] = '0;
      endcase
      load_key();
      run_random(RandomPerPhase);
      drain();
    end

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- playfair_digraph_encrypt.f -----
rtl/pf_pkg.sv
rtl/pf_ifs.sv
rtl/playfair_digraph_encrypt.sv
tb/playfair_digraph_encrypt_checker.sv
tb/playfair_digraph_encrypt_tb.sv
